/* src/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg: shared types and codes of the two-level priority print queue
// Command and result payloads, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_PRINT   = 3'd1;
  localparam logic [2:0] OP_SEARCH  = 3'd2;
  localparam logic [2:0] OP_TOTAL   = 3'd3;
  localparam logic [2:0] OP_SHOW    = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_INIT  = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [2:0] STAT_NOTHING   = 3'd5;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        priority_req;
    logic [15:0] doc_id;
    logic [15:0] page_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        from_priority;
    logic [15:0] entry_id;
    logic [15:0] entry_pages;
    logic [20:0] total_pages;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRINT,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

/* src/tpq_ram.sv */
// ----------------------------------------------------------------------------
// tpq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/two_level_priority_print_queue.sv */
// ----------------------------------------------------------------------------
// two_level_priority_print_queue: two circular job FIFOs, strict priority
// Enqueue, clear and error results are registered, seen the cycle after accept;
// print reads the head entry, ST_PRINT registers it; search, show and total walk
// the queue(s), total normal then priority. busy is high until the final strobe,
// so a walk fully holds the block; enqueue, clear and errors take one per cycle.
// Walks do one entry per cycle on the single RAM read port; receiver can't stall.
// Reset (rst, synchronous): both queues empty, not initialized, capacity 16.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_print_queue
  import tpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // command channel
  input  wire logic       start,
  output logic            busy,
  input  wire cmd_t       cmd,
  // capacity register write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data,
  // result strobe
  output logic            rsp_valid,
  output rsp_t            rsp
);

  localparam int CW   = $clog2(DEPTH + 1);   // count / capacity width
  localparam int IW   = $clog2(DEPTH);       // index within a queue
  localparam int AW   = $clog2(2 * DEPTH);   // entry RAM address
  localparam int CAPW = (CW > 5) ? CW : 5;   // width for capacity clamp

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t          state, state_next;
  logic            ready_flag, ready_flag_next;
  logic [IW-1:0]   head [2];
  logic [IW-1:0]   head_next [2];
  logic [CW-1:0]   count [2];
  logic [CW-1:0]   count_next [2];
  logic [CW-1:0]   active_cap, active_cap_next;
  logic [4:0]      queue_capacity;

  // latched command
  logic [2:0]      op_r, op_r_next;
  logic            q_r, q_r_next;
  logic [15:0]     id_r, id_r_next;

  // walk sequencer: issue one read per cycle, evaluate it the next
  logic            walk_q, walk_q_next;
  logic [IW-1:0]   rd_idx, rd_idx_next;
  logic [CW-1:0]   rd_left, rd_left_next;
  logic            pend, pend_next;          // a read was issued last cycle
  logic            pend_last, pend_last_next; // ... and it was the final one
  logic [20:0]     sum, sum_next;

  logic            rsp_valid_next;
  rsp_t            rsp_next;

  // entry RAM: {doc_id, page_count}
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  tpq_ram #(
    .WIDTH (32),
    .DEPTH (2 * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Queue q lives at slots q*DEPTH .. q*DEPTH+DEPTH-1.
  function automatic logic [AW-1:0] slot(input logic q, input logic [IW-1:0] idx);
    slot = q ? (AW'(DEPTH) + AW'(idx)) : AW'(idx);
  endfunction

  // Circular advance under the capacity sampled at clear.
  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                        input logic [CW-1:0] cap);
    logic [CW-1:0] s;
    s = CW'(idx) + CW'(1);
    adv = (s >= cap) ? '0 : IW'(s);
  endfunction

  // Config must only be written while idle (the block does not enforce it); always take it.
  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ready_flag     <= 1'b0;
      head[0]        <= '0;
      head[1]        <= '0;
      count[0]       <= '0;
      count[1]       <= '0;
      active_cap     <= CW'(DEPTH);
      queue_capacity <= CAPACITY_RESET;
      rsp_valid      <= 1'b0;
      pend           <= 1'b0;
    end else begin
      state      <= state_next;
      ready_flag <= ready_flag_next;
      head[0]    <= head_next[0];
      head[1]    <= head_next[1];
      count[0]   <= count_next[0];
      count[1]   <= count_next[1];
      active_cap <= active_cap_next;
      rsp_valid  <= rsp_valid_next;
      pend       <= pend_next;
      if (cfg_valid && cfg_ready) begin
        queue_capacity <= cfg_data;
      end
    end
  end

  // payload and walk data, no reset needed
  always_ff @(posedge clk) begin
    op_r      <= op_r_next;
    q_r       <= q_r_next;
    id_r      <= id_r_next;
    walk_q    <= walk_q_next;
    rd_idx    <= rd_idx_next;
    rd_left   <= rd_left_next;
    pend_last <= pend_last_next;
    sum       <= sum_next;
    rsp       <= rsp_next;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [CAPW-1:0] cap_ext;
  logic [CW:0]     tail;
  logic            src;
  logic            done;

  always_comb begin
    state_next      = state;
    ready_flag_next = ready_flag;
    head_next[0]    = head[0];
    head_next[1]    = head[1];
    count_next[0]   = count[0];
    count_next[1]   = count[1];
    active_cap_next = active_cap;
    op_r_next       = op_r;
    q_r_next        = q_r;
    id_r_next       = id_r;
    walk_q_next     = walk_q;
    rd_idx_next     = rd_idx;
    rd_left_next    = rd_left;
    pend_next       = 1'b0;
    pend_last_next  = pend_last;
    sum_next        = sum;

    rsp_valid_next      = 1'b0;
    rsp_next            = '0;
    rsp_next.from_priority = q_r;
    rsp_next.last       = 1'b1;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {cmd.doc_id, cmd.page_count};
    ram_raddr = '0;

    cap_ext = CAPW'(queue_capacity);
    tail    = '0;
    src     = 1'b0;
    done    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_r_next              = cmd.opcode;
          q_r_next               = cmd.priority_req;
          id_r_next              = cmd.doc_id;
          rsp_next.from_priority = cmd.priority_req;
          priority case (cmd.opcode)
            OP_ENQUEUE: begin
              rsp_valid_next = 1'b1;
              if (!ready_flag) begin
                rsp_next.status = STAT_NOT_INIT;
              end else if (count[cmd.priority_req] >= active_cap) begin
                rsp_next.status = STAT_FULL;
              end else begin
                tail = (CW + 1)'(head[cmd.priority_req])
                     + (CW + 1)'(count[cmd.priority_req]);
                if (tail >= (CW + 1)'(active_cap)) begin
                  tail = tail - (CW + 1)'(active_cap);
                end
                ram_we    = 1'b1;
                ram_waddr = slot(cmd.priority_req, IW'(tail));
                count_next[cmd.priority_req] = count[cmd.priority_req] + CW'(1);
                rsp_next.status = STAT_OK;
              end
            end
            OP_PRINT: begin
              if (!ready_flag) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_NOT_INIT;
              end else if (count[1] == '0 && count[0] == '0) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_NOTHING;
              end else begin
                // strict priority: queue 1 first
                src            = (count[1] != '0);
                q_r_next       = src;
                ram_raddr      = slot(src, head[src]);
                head_next[src] = adv(head[src], active_cap);
                count_next[src] = count[src] - CW'(1);
                state_next     = ST_PRINT;
              end
            end
            OP_SEARCH, OP_SHOW: begin
              if (!ready_flag) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_NOT_INIT;
              end else if (count[cmd.priority_req] == '0) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_EMPTY;
              end else begin
                walk_q_next  = cmd.priority_req;
                rd_idx_next  = head[cmd.priority_req];
                rd_left_next = count[cmd.priority_req];
                state_next   = ST_WALK;
              end
            end
            OP_TOTAL: begin
              // both queues, normal first; no init check needed
              walk_q_next  = 1'b0;
              rd_idx_next  = head[0];
              rd_left_next = count[0];
              sum_next     = '0;
              state_next   = ST_WALK;
            end
            OP_CLEAR: begin
              if (cap_ext == '0) begin
                active_cap_next = CW'(1);
              end else if (cap_ext > CAPW'(DEPTH)) begin
                active_cap_next = CW'(DEPTH);
              end else begin
                active_cap_next = CW'(cap_ext);
              end
              head_next[0]    = '0;
              head_next[1]    = '0;
              count_next[0]   = '0;
              count_next[1]   = '0;
              ready_flag_next = 1'b1;
              rsp_valid_next  = 1'b1;
              rsp_next.status = STAT_OK;
            end
            default: begin
              // undefined opcode: dropped, no result
            end
          endcase
        end
      end

      ST_PRINT: begin
        rsp_valid_next       = 1'b1;
        rsp_next.status      = STAT_OK;
        rsp_next.entry_id    = ram_rdata[31:16];
        rsp_next.entry_pages = ram_rdata[15:0];
        state_next           = ST_IDLE;
      end

      ST_WALK: begin
        // evaluate the entry read last cycle
        if (pend) begin
          priority case (op_r)
            OP_SEARCH: begin
              if (ram_rdata[31:16] == id_r) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_OK;
                done            = 1'b1;
              end else if (pend_last) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = STAT_NOT_FOUND;
                done            = 1'b1;
              end
            end
            OP_SHOW: begin
              rsp_valid_next       = 1'b1;
              rsp_next.status      = STAT_OK;
              rsp_next.entry_id    = ram_rdata[31:16];
              rsp_next.entry_pages = ram_rdata[15:0];
              rsp_next.last        = pend_last;
              done                 = pend_last;
            end
            default: begin
              sum_next = sum + 21'(ram_rdata[15:0]);
            end
          endcase
        end

        // issue the next read
        if (!done) begin
          if (rd_left != '0) begin
            ram_raddr      = slot(walk_q, rd_idx);
            rd_idx_next    = adv(rd_idx, active_cap);
            rd_left_next   = rd_left - CW'(1);
            pend_next      = 1'b1;
            pend_last_next = (rd_left == CW'(1));
          end else if (op_r == OP_TOTAL) begin
            if (!walk_q) begin
              walk_q_next  = 1'b1;
              rd_idx_next  = head[1];
              rd_left_next = count[1];
            end else if (!pend) begin
              rsp_valid_next       = 1'b1;
              rsp_next.status      = STAT_OK;
              rsp_next.total_pages = sum;
              done                 = 1'b1;
            end
          end
        end

        if (done) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
